// ===== hw/rtl/ata_seq_pkg.sv =====
package ata_seq_pkg;

  // Input request codes (s_tuser)
  localparam logic [2:0] CMD_START_RD = 3'd0;
  localparam logic [2:0] CMD_START_WR = 3'd1;
  localparam logic [2:0] CMD_STATUS   = 3'd2;
  localparam logic [2:0] CMD_RD_WORD  = 3'd3;
  localparam logic [2:0] CMD_WR_WORD  = 3'd4;

  // Result bus operations (m_tuser)
  localparam logic [2:0] OP_NONE    = 3'd0;
  localparam logic [2:0] OP_REG_WR  = 3'd1;
  localparam logic [2:0] OP_REG_RD  = 3'd2;
  localparam logic [2:0] OP_CTRL_WR = 3'd3;
  localparam logic [2:0] OP_CTRL_RD = 3'd4;
  localparam logic [2:0] OP_TO_HOST = 3'd5;
  localparam logic [2:0] OP_DONE    = 3'd6;

  // Task-file offsets
  localparam logic [2:0] TF_DATA   = 3'd0;
  localparam logic [2:0] TF_COUNT  = 3'd2;
  localparam logic [2:0] TF_LBA_LO = 3'd3;
  localparam logic [2:0] TF_LBA_MD = 3'd4;
  localparam logic [2:0] TF_LBA_HI = 3'd5;
  localparam logic [2:0] TF_DRIVE  = 3'd6;
  localparam logic [2:0] TF_STATUS = 3'd7;

  // Drive commands and fixed bytes
  localparam logic [7:0] ATA_READ_SECTORS  = 8'h20;
  localparam logic [7:0] ATA_WRITE_SECTORS = 8'h30;
  localparam logic [7:0] ATA_FLUSH_CACHE   = 8'hE7;
  localparam logic [7:0] DRV_BASE          = 8'hE0;
  localparam logic [7:0] SECTOR_COUNT_ONE  = 8'h01;
  localparam logic [7:0] CTRL_CLEAR        = 8'h00;

  // Status bits
  localparam int BSY_BIT = 7;
  localparam int DF_BIT  = 5;
  localparam int DRQ_BIT = 3;
  localparam int ERR_BIT = 0;

  // Configuration port
  localparam int         APB_ADDR_W   = 3;
  localparam logic       REG_IDX_DRV  = 1'b0;
  localparam logic       REG_IDX_RTRY = 1'b1;
  localparam logic [3:0] RETRY_RESET  = 4'd4;

  // Number of alternate-status reads in a wait
  localparam logic [3:0] WAIT_ALT_READS = 4'd4;

  typedef struct packed {
    logic       drive_is_slave;
    logic [3:0] retry_limit;
  } cfg_t;

  // Burst kinds: one per distinct result sequence an input can cause
  typedef enum logic [3:0] {
    K_START,       // control write, then wait
    K_STATUS,      // single status read
    K_RD_SETUP,    // drive select, read setup, wait
    K_WR_SELECT,   // drive select, wait
    K_WR_SETUP,    // write setup, wait
    K_DONE_OK,
    K_DONE_FAIL,
    K_DATA_REQ,    // data word read request
    K_RWORD_MORE,  // word to host, next data request
    K_RWORD_LAST,  // word to host, wait
    K_WWORD,       // data register write
    K_WWORD_LAST   // data register write, flush, wait
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  drv_byte;
    logic [23:0] lba;
    logic [15:0] word;
  } desc_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [2:0]  addr;
    logic [7:0]  bus_byte;
    logic [15:0] word;
    logic        success;
    logic        last;
  } res_t;

  function automatic res_t setup_item(logic [3:0] j, logic [7:0] cmd_byte, logic [23:0] lba);
    res_t r;
    r = '0;
    r.op = OP_REG_WR;
    case (j)
      4'd0: begin r.addr = TF_COUNT;  r.bus_byte = SECTOR_COUNT_ONE; end
      4'd1: begin r.addr = TF_LBA_LO; r.bus_byte = lba[7:0];   end
      4'd2: begin r.addr = TF_LBA_MD; r.bus_byte = lba[15:8];  end
      4'd3: begin r.addr = TF_LBA_HI; r.bus_byte = lba[23:16]; end
      default: begin r.addr = TF_STATUS; r.bus_byte = cmd_byte; end
    endcase
    return r;
  endfunction

  // Result number idx of a burst: a head of kind-specific items, then an
  // optional wait tail of alternate-status reads and one status read.
  function automatic res_t expand_item(desc_t d, logic [3:0] idx);
    res_t       r;
    logic [3:0] head;
    logic       has_wait;
    logic [3:0] w;
    r        = '0;
    head     = 4'd1;
    has_wait = 1'b0;
    case (d.kind)
      K_START:      begin head = 4'd1; has_wait = 1'b1; end
      K_RD_SETUP:   begin head = 4'd6; has_wait = 1'b1; end
      K_WR_SELECT:  begin head = 4'd1; has_wait = 1'b1; end
      K_WR_SETUP:   begin head = 4'd5; has_wait = 1'b1; end
      K_RWORD_MORE: begin head = 4'd2; has_wait = 1'b0; end
      K_RWORD_LAST: begin head = 4'd1; has_wait = 1'b1; end
      K_WWORD_LAST: begin head = 4'd2; has_wait = 1'b1; end
      default:      begin head = 4'd1; has_wait = 1'b0; end
    endcase
    w = idx - head;
    if (idx < head) begin
      case (d.kind)
        K_START: begin
          r.op = OP_CTRL_WR; r.bus_byte = CTRL_CLEAR;
        end
        K_STATUS: begin
          r.op = OP_REG_RD; r.addr = TF_STATUS;
        end
        K_RD_SETUP: begin
          if (idx == 4'd0) begin
            r.op = OP_REG_WR; r.addr = TF_DRIVE; r.bus_byte = d.drv_byte;
          end else begin
            r = setup_item(idx - 4'd1, ATA_READ_SECTORS, d.lba);
          end
        end
        K_WR_SELECT: begin
          r.op = OP_REG_WR; r.addr = TF_DRIVE; r.bus_byte = d.drv_byte;
        end
        K_WR_SETUP: begin
          r = setup_item(idx, ATA_WRITE_SECTORS, d.lba);
        end
        K_DONE_OK: begin
          r.op = OP_DONE; r.success = 1'b1;
        end
        K_DONE_FAIL: begin
          r.op = OP_DONE;
        end
        K_DATA_REQ: begin
          r.op = OP_REG_RD; r.addr = TF_DATA;
        end
        K_RWORD_MORE: begin
          if (idx == 4'd0) begin
            r.op = OP_TO_HOST; r.word = d.word;
          end else begin
            r.op = OP_REG_RD; r.addr = TF_DATA;
          end
        end
        K_RWORD_LAST: begin
          r.op = OP_TO_HOST; r.word = d.word;
        end
        K_WWORD: begin
          r.op = OP_REG_WR; r.addr = TF_DATA; r.word = d.word;
        end
        K_WWORD_LAST: begin
          if (idx == 4'd0) begin
            r.op = OP_REG_WR; r.addr = TF_DATA; r.word = d.word;
          end else begin
            r.op = OP_REG_WR; r.addr = TF_STATUS; r.bus_byte = ATA_FLUSH_CACHE;
          end
        end
        default: begin
          r.op = OP_NONE;
        end
      endcase
    end else if (w < WAIT_ALT_READS) begin
      r.op = OP_CTRL_RD;
    end else begin
      r.op = OP_REG_RD; r.addr = TF_STATUS;
    end
    r.last = has_wait ? (idx == head + WAIT_ALT_READS) : (idx == head - 4'd1);
    return r;
  endfunction

endpackage

// ===== hw/rtl/ata_pio_sector_sequencer.sv =====
// Host-side sequencer for one-sector ATA LBA28 PIO transfers. Each input
// request (start read, start write, status reply, data word from the drive,
// data word from the host) is decoded into a burst of 0 to 11 bus requests,
// which then leave on the output stream one per cycle while m_tready is
// high, the final one of a burst flagged with m_tlast. Inputs that cause one
// result, such as busy polls and host data words, then flow at one per cycle.
// The rate is set by the single output port of the burst expander; one burst
// waits in a holding register while the previous one drains, so a new input
// is taken as long as that register is free. An accepted input passes
// through the holding register, then the expander's current-burst register,
// before its first result appears. The user must write configuration through
// the APB port only while no transfer is running; the block does not enforce it.
module ata_pio_sector_sequencer #(
  parameter int SECTOR_WORDS = 256
) (
  input  logic                               clk,
  input  logic                               rst,
  // APB configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ata_seq_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  // input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [55:0]                        s_tdata,  // sector_addr[27:0], status_byte[35:28],
                                                       // data_word[51:36], zero fill
  input  logic [2:0]                         s_tuser,  // cmd
  // result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [31:0]                        m_tdata,  // reg_addr[2:0], bus_byte[10:3],
                                                       // word_out[26:11], success[27], zero fill
  output logic [2:0]                         m_tuser,  // bus_op
  output logic                               m_tlast   // last
);

  ata_seq_pkg::cfg_t  cfg;
  ata_seq_pkg::desc_t desc;
  ata_seq_pkg::res_t  res;
  logic               desc_valid;
  logic               desc_ready;

  // Configuration registers: drive select bit and retry limit
  ata_seq_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Transfer state machine: track the phase across requests, hand off a burst
  ata_seq_ctrl #(
    .SECTOR_WORDS (SECTOR_WORDS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .cmd         (s_tuser),
    .sector_addr (s_tdata[27:0]),
    .status_byte (s_tdata[35:28]),
    .data_word   (s_tdata[51:36]),
    .desc_valid  (desc_valid),
    .desc        (desc),
    .desc_ready  (desc_ready)
  );

  // Burst expander: walk the held burst one bus request per cycle while m_tready is high
  ata_seq_expand u_expand (
    .clk        (clk),
    .rst        (rst),
    .desc_valid (desc_valid),
    .desc       (desc),
    .desc_ready (desc_ready),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .res        (res)
  );

  assign m_tuser = res.op;
  assign m_tlast = res.last;
  assign m_tdata = {4'd0, res.success, res.word, res.bus_byte, res.addr};

endmodule

// ===== hw/rtl/ata_seq_regs.sv =====
module ata_seq_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ata_seq_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  output ata_seq_pkg::cfg_t                  cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.drive_is_slave <= 1'b0;
      cfg.retry_limit    <= ata_seq_pkg::RETRY_RESET;
    end else if (wr_en) begin
      if (paddr[2] == ata_seq_pkg::REG_IDX_DRV) begin
        cfg.drive_is_slave <= pwdata[0];
      end else begin
        cfg.retry_limit <= pwdata[3:0];
      end
    end
  end

  // Word-aligned decode: low address bits are ignored
  always_comb begin
    if (paddr[2] == ata_seq_pkg::REG_IDX_RTRY) begin
      prdata = {28'd0, cfg.retry_limit};
    end else begin
      prdata = {31'd0, cfg.drive_is_slave};
    end
  end

endmodule

// ===== hw/rtl/ata_seq_ctrl.sv =====
module ata_seq_ctrl #(
  parameter int SECTOR_WORDS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  ata_seq_pkg::cfg_t  cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         cmd,
  input  logic [27:0]        sector_addr,
  input  logic [7:0]         status_byte,
  input  logic [15:0]        data_word,
  output logic               desc_valid,
  output ata_seq_pkg::desc_t desc,
  input  logic               desc_ready
);

  localparam int IDX_W = $clog2(SECTOR_WORDS + 1);

  typedef enum logic [2:0] {
    PH_IDLE, PH_POLL, PH_CHECK, PH_RDATA, PH_WDATA
  } phase_t;

  typedef enum logic [2:0] {
    NX_RD_SETUP, NX_RD_CHECK, NX_RD_FINISH, NX_WR_SELECT,
    NX_WR_SETUP, NX_WR_DATA, NX_WR_FINISH
  } step_t;

  phase_t             phase, phase_next;
  step_t              after_wait_step, after_wait_step_next;
  logic [3:0]         error_count, error_count_next;
  logic [IDX_W-1:0]   word_index, word_index_next;
  logic [27:0]        held_addr, held_addr_next;
  logic               push;
  ata_seq_pkg::kind_t kind;
  ata_seq_pkg::desc_t desc_next;
  logic               accept;
  logic [IDX_W-1:0]   word_inc;
  logic               words_done;
  logic               status_err;

  assign in_ready   = !desc_valid || desc_ready;
  assign accept     = in_valid && in_ready;
  assign word_inc   = word_index + 1'b1;
  assign words_done = (word_inc == IDX_W'(SECTOR_WORDS));
  assign status_err = status_byte[ata_seq_pkg::ERR_BIT] | status_byte[ata_seq_pkg::DF_BIT] |
                      ~status_byte[ata_seq_pkg::DRQ_BIT];

  always_comb begin
    phase_next           = phase;
    after_wait_step_next = after_wait_step;
    error_count_next     = error_count;
    word_index_next      = word_index;
    held_addr_next       = held_addr;
    push                 = 1'b0;
    kind                 = ata_seq_pkg::K_STATUS;
    if (accept) begin
      case (phase)
        PH_IDLE: begin
          if (cmd == ata_seq_pkg::CMD_START_RD || cmd == ata_seq_pkg::CMD_START_WR) begin
            held_addr_next       = sector_addr;
            error_count_next     = 4'd0;
            word_index_next      = '0;
            push                 = 1'b1;
            kind                 = ata_seq_pkg::K_START;
            after_wait_step_next = (cmd == ata_seq_pkg::CMD_START_WR) ? NX_WR_SELECT
                                                                       : NX_RD_SETUP;
            phase_next           = PH_POLL;
          end
        end
        PH_POLL: begin
          if (cmd == ata_seq_pkg::CMD_STATUS) begin
            if (status_byte[ata_seq_pkg::BSY_BIT]) begin
              push = 1'b1;
              kind = ata_seq_pkg::K_STATUS;
            end else begin
              case (after_wait_step)
                NX_RD_SETUP: begin
                  push = 1'b1;
                  kind = ata_seq_pkg::K_RD_SETUP;
                  after_wait_step_next = NX_RD_CHECK;
                end
                NX_RD_CHECK: begin
                  push       = 1'b1;
                  kind       = ata_seq_pkg::K_STATUS;
                  phase_next = PH_CHECK;
                end
                NX_WR_SELECT: begin
                  push = 1'b1;
                  kind = ata_seq_pkg::K_WR_SELECT;
                  after_wait_step_next = NX_WR_SETUP;
                end
                NX_WR_SETUP: begin
                  push = 1'b1;
                  kind = ata_seq_pkg::K_WR_SETUP;
                  after_wait_step_next = NX_WR_DATA;
                end
                NX_WR_DATA: begin
                  // no result: wait for host words
                  word_index_next = '0;
                  phase_next      = PH_WDATA;
                end
                default: begin
                  push       = 1'b1;
                  kind       = ata_seq_pkg::K_DONE_OK;
                  phase_next = PH_IDLE;
                end
              endcase
            end
          end
        end
        PH_CHECK: begin
          if (cmd == ata_seq_pkg::CMD_STATUS) begin
            push = 1'b1;
            if (status_err) begin
              if (error_count >= cfg.retry_limit) begin
                kind       = ata_seq_pkg::K_DONE_FAIL;
                phase_next = PH_IDLE;
              end else begin
                error_count_next     = error_count + 4'd1;
                kind                 = ata_seq_pkg::K_START;
                after_wait_step_next = NX_RD_SETUP;
                phase_next           = PH_POLL;
              end
            end else begin
              word_index_next = '0;
              kind            = ata_seq_pkg::K_DATA_REQ;
              phase_next      = PH_RDATA;
            end
          end
        end
        PH_RDATA: begin
          if (cmd == ata_seq_pkg::CMD_RD_WORD) begin
            push            = 1'b1;
            word_index_next = word_inc;
            if (words_done) begin
              kind                 = ata_seq_pkg::K_RWORD_LAST;
              after_wait_step_next = NX_RD_FINISH;
              phase_next           = PH_POLL;
            end else begin
              kind = ata_seq_pkg::K_RWORD_MORE;
            end
          end
        end
        PH_WDATA: begin
          if (cmd == ata_seq_pkg::CMD_WR_WORD) begin
            push            = 1'b1;
            word_index_next = word_inc;
            if (words_done) begin
              kind                 = ata_seq_pkg::K_WWORD_LAST;
              after_wait_step_next = NX_WR_FINISH;
              phase_next           = PH_POLL;
            end else begin
              kind = ata_seq_pkg::K_WWORD;
            end
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    desc_next.kind     = kind;
    desc_next.drv_byte = ata_seq_pkg::DRV_BASE |
                         {3'd0, cfg.drive_is_slave, held_addr[27:24]};
    desc_next.lba      = held_addr[23:0];
    desc_next.word     = data_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      after_wait_step <= NX_RD_SETUP;
      error_count     <= 4'd0;
      word_index      <= '0;
      held_addr       <= 28'd0;
      desc_valid      <= 1'b0;
    end else begin
      phase           <= phase_next;
      after_wait_step <= after_wait_step_next;
      error_count     <= error_count_next;
      word_index      <= word_index_next;
      held_addr       <= held_addr_next;
      if (accept) begin
        desc_valid <= push;
        desc       <= desc_next;
      end else if (desc_ready) begin
        desc_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/ata_seq_expand.sv =====
module ata_seq_expand (
  input  logic               clk,
  input  logic               rst,
  input  logic               desc_valid,
  input  ata_seq_pkg::desc_t desc,
  output logic               desc_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output ata_seq_pkg::res_t  res
);

  ata_seq_pkg::desc_t cur;
  logic               cur_valid;
  logic [3:0]         idx;
  logic               take;

  assign res        = ata_seq_pkg::expand_item(cur, idx);
  assign out_valid  = cur_valid;
  assign take       = out_valid && out_ready;
  assign desc_ready = !cur_valid || (take && res.last);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 4'd0;
    end else if (desc_ready) begin
      cur_valid <= desc_valid;
      idx       <= 4'd0;
    end else if (take) begin
      idx <= idx + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (desc_ready) begin
      cur <= desc;
    end
  end

endmodule

// ===== sim/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ata_seq_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int SECTOR_WORDS = 256;
  localparam int CYCLE_LIMIT  = 300_000;
  localparam int MAX_REPORTS  = 10;
  localparam int SETTLE_TICKS = 8;
  // Data words sent in the closing read, which stays open at the end
  localparam int PART_WORDS   = 40;

  // APB byte addresses of the two configuration registers
  localparam logic [APB_ADDR_W-1:0] REG_ADDR_SLAVE = 3'd0;
  localparam logic [APB_ADDR_W-1:0] REG_ADDR_RETRY = 3'd4;

  // reg_addr value carried by results that are not register accesses
  localparam logic [2:0] NO_REG = 3'd0;

  localparam logic [27:0] LBA_MAX = 28'hFFF_FFFF;

  typedef enum logic [2:0] {
    SEQ_IDLE, SEQ_POLL, SEQ_CHECK, SEQ_RDATA, SEQ_WDATA
  } seq_phase_t;

  // What the sequencer does once a status poll finds the drive not busy
  typedef enum logic [2:0] {
    NEXT_RD_SETUP, NEXT_RD_CHECK, NEXT_RD_FINISH,
    NEXT_WR_SELECT, NEXT_WR_SETUP, NEXT_WR_DATA, NEXT_WR_FINISH
  } wait_next_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [27:0] lba;
    logic [7:0]  status;
    logic [15:0] word;
  } seq_request_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [2:0]  addr;
    logic [7:0]  data_byte;
    logic [15:0] word;
    logic        ok;
    logic        last;
  } bus_req_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [APB_ADDR_W-1:0] paddr    = '0;
  logic [31:0]           pwdata   = '0;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [55:0]           s_tdata  = '0;  // sector_addr[27:0], status_byte[35:28],
                                         // data_word[51:36], zero fill
  logic [2:0]            s_tuser  = '0;  // cmd
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [31:0]           m_tdata;        // reg_addr[2:0], bus_byte[10:3],
                                         // word_out[26:11], success[27], zero fill
  logic [2:0]            m_tuser;        // bus_op
  logic                  m_tlast;

  ata_pio_sector_sequencer #(
    .SECTOR_WORDS(SECTOR_WORDS)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Sequencer prediction: configuration mirror, transfer state, and the bus
  // requests still owed by the block, oldest first.
  // ---------------------------------------------------------------------------
  logic       cfg_slave = 1'b0;
  logic [3:0] cfg_retry = RETRY_RESET;

  seq_phase_t  seq_ph     = SEQ_IDLE;
  wait_next_t  after_wait = NEXT_RD_SETUP;
  logic [3:0]  err_tally  = '0;
  int          word_tally = 0;
  logic [27:0] lba_hold   = '0;

  bus_req_t burst_q[$];
  bus_req_t owed_q[$];

  task automatic add_req(logic [2:0] op, logic [2:0] addr, logic [7:0] data_byte,
                         logic [15:0] word, logic ok);
    bus_req_t r;
    r.op        = op;
    r.addr      = addr;
    r.data_byte = data_byte;
    r.word      = word;
    r.ok        = ok;
    r.last      = 1'b0;
    burst_q = {burst_q, r};
  endtask

  // Four alternate-status reads, then the first status poll.
  task automatic start_wait(wait_next_t nxt);
    repeat (WAIT_ALT_READS) add_req(OP_CTRL_RD, NO_REG, '0, '0, 1'b0);
    add_req(OP_REG_RD, TF_STATUS, '0, '0, 1'b0);
    after_wait = nxt;
    seq_ph     = SEQ_POLL;
  endtask

  task automatic open_attempt(wait_next_t nxt);
    add_req(OP_CTRL_WR, NO_REG, CTRL_CLEAR, '0, 1'b0);
    start_wait(nxt);
  endtask

  task automatic drive_select();
    add_req(OP_REG_WR, TF_DRIVE,
            DRV_BASE | {3'b000, cfg_slave, 4'b0000} | {4'b0000, lba_hold[27:24]},
            '0, 1'b0);
  endtask

  task automatic task_file_setup(logic [7:0] command);
    add_req(OP_REG_WR, TF_COUNT,  SECTOR_COUNT_ONE,  '0, 1'b0);
    add_req(OP_REG_WR, TF_LBA_LO, lba_hold[7:0],     '0, 1'b0);
    add_req(OP_REG_WR, TF_LBA_MD, lba_hold[15:8],    '0, 1'b0);
    add_req(OP_REG_WR, TF_LBA_HI, lba_hold[23:16],   '0, 1'b0);
    add_req(OP_REG_WR, TF_STATUS, command,           '0, 1'b0);
  endtask

  task automatic end_transfer(logic ok);
    add_req(OP_DONE, NO_REG, '0, '0, ok);
    seq_ph = SEQ_IDLE;
  endtask

  task automatic wait_over();
    case (after_wait)
      NEXT_RD_SETUP: begin
        drive_select();
        task_file_setup(ATA_READ_SECTORS);
        start_wait(NEXT_RD_CHECK);
      end
      NEXT_RD_CHECK: begin
        add_req(OP_REG_RD, TF_STATUS, '0, '0, 1'b0);
        seq_ph = SEQ_CHECK;
      end
      NEXT_WR_SELECT: begin
        drive_select();
        start_wait(NEXT_WR_SETUP);
      end
      NEXT_WR_SETUP: begin
        task_file_setup(ATA_WRITE_SECTORS);
        start_wait(NEXT_WR_DATA);
      end
      NEXT_WR_DATA: begin
        // no bus request: the block now waits for host words
        word_tally = 0;
        seq_ph     = SEQ_WDATA;
      end
      default: begin
        end_transfer(1'b1);
      end
    endcase
  endtask

  // Advance the mirrored state by one accepted request and queue the bus
  // requests it causes; anything out of place leaves no trace.
  task automatic predict_sequencer(seq_request_t rq);
    burst_q.delete();
    if (seq_ph == SEQ_IDLE && (rq.cmd == CMD_START_RD || rq.cmd == CMD_START_WR)) begin
      lba_hold   = rq.lba;
      err_tally  = '0;
      word_tally = 0;
      open_attempt(rq.cmd == CMD_START_WR ? NEXT_WR_SELECT : NEXT_RD_SETUP);
    end else if (seq_ph == SEQ_POLL && rq.cmd == CMD_STATUS) begin
      if (rq.status[BSY_BIT]) begin
        add_req(OP_REG_RD, TF_STATUS, '0, '0, 1'b0);
      end else begin
        wait_over();
      end
    end else if (seq_ph == SEQ_CHECK && rq.cmd == CMD_STATUS) begin
      if (rq.status[ERR_BIT] || rq.status[DF_BIT] || !rq.status[DRQ_BIT]) begin
        if (err_tally >= cfg_retry) begin
          end_transfer(1'b0);
        end else begin
          err_tally = err_tally + 4'd1;
          open_attempt(NEXT_RD_SETUP);
        end
      end else begin
        word_tally = 0;
        add_req(OP_REG_RD, TF_DATA, '0, '0, 1'b0);
        seq_ph = SEQ_RDATA;
      end
    end else if (seq_ph == SEQ_RDATA && rq.cmd == CMD_RD_WORD) begin
      add_req(OP_TO_HOST, NO_REG, '0, rq.word, 1'b0);
      word_tally++;
      if (word_tally >= SECTOR_WORDS) begin
        start_wait(NEXT_RD_FINISH);
      end else begin
        add_req(OP_REG_RD, TF_DATA, '0, '0, 1'b0);
      end
    end else if (seq_ph == SEQ_WDATA && rq.cmd == CMD_WR_WORD) begin
      add_req(OP_REG_WR, TF_DATA, '0, rq.word, 1'b0);
      word_tally++;
      if (word_tally >= SECTOR_WORDS) begin
        add_req(OP_REG_WR, TF_STATUS, ATA_FLUSH_CACHE, '0, 1'b0);
        start_wait(NEXT_WR_FINISH);
      end
    end
    if (burst_q.size() != 0) burst_q[burst_q.size() - 1].last = 1'b1;
    foreach (burst_q[i]) owed_q = {owed_q, burst_q[i]};
  endtask

  // ---------------------------------------------------------------------------
  // Handshake pacing: a random gap after each request, with occasional
  // stretches of back-to-back traffic.
  // ---------------------------------------------------------------------------
  function automatic int draw_gap(inout bit steady);
    if ($urandom_range(0, 39) == 0) steady = !steady;
    return steady ? 0 : int'($urandom_range(0, 7));
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: present the next pending request, hold it until taken,
  // then predict its bus requests at the accepting edge.
  // ---------------------------------------------------------------------------
  seq_request_t pending_q[$];
  seq_request_t in_flight;
  int           send_gap  = 0;
  bit           tx_steady = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap = 0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) predict_sequencer(in_flight);
      if (send_gap != 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        in_flight = pending_q.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= in_flight.cmd;
        s_tdata  <= {4'b0000, in_flight.word, in_flight.status, in_flight.lba};
        send_gap = draw_gap(tx_steady);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compare every taken bus request with the oldest one owed,
  // then stall m_tready for a drawn number of cycles.
  // ---------------------------------------------------------------------------
  int fault_count = 0;
  int recv_gap    = 0;
  bit rx_steady   = 1'b0;

  task automatic flag_fault(string what, bus_req_t want, bus_req_t got);
    fault_count++;
    if (fault_count <= MAX_REPORTS) begin
      $display("%0t %s: expected op %0d reg %0d byte %h word %h ok %b last %b",
               $realtime, what, want.op, want.addr, want.data_byte, want.word,
               want.ok, want.last);
      $display("%0t %s:      got op %0d reg %0d byte %h word %h ok %b last %b",
               $realtime, what, got.op, got.addr, got.data_byte, got.word,
               got.ok, got.last);
    end
  endtask

  always @(posedge clk) begin
    bus_req_t got;
    bus_req_t want;
    if (rst) begin
      m_tready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.op        = m_tuser;
        got.addr      = m_tdata[2:0];
        got.data_byte = m_tdata[10:3];
        got.word      = m_tdata[26:11];
        got.ok        = m_tdata[27];
        got.last      = m_tlast;
        if (owed_q.size() == 0) begin
          flag_fault("unexpected request", '0, got);
        end else begin
          want = owed_q.pop_front();
          if (got !== want) flag_fault("mismatch", want, got);
        end
        recv_gap = draw_gap(rx_steady);
      end else if (recv_gap != 0) begin
        recv_gap--;
      end
      m_tready <= (recv_gap == 0);
    end
  end

  // Hard stop for a hung handshake or requests that never come out.
  int cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus building blocks
  // ---------------------------------------------------------------------------
  task automatic queue_request(logic [2:0] cmd, logic [27:0] lba, logic [7:0] status,
                               logic [15:0] word);
    seq_request_t rq;
    rq.cmd    = cmd;
    rq.lba    = lba;
    rq.status = status;
    rq.word   = word;
    pending_q = {pending_q, rq};
  endtask

  // Now and then drop in a request that does not belong to this phase,
  // including starts during a transfer and codes above the defined range.
  task automatic maybe_noise(seq_phase_t ph);
    logic [2:0] cmd;
    bit         fits;
    if ($urandom_range(0, 9) == 0) begin
      do begin
        cmd = 3'($urandom_range(0, 7));
        case (ph)
          SEQ_IDLE:  fits = (cmd == CMD_START_RD || cmd == CMD_START_WR);
          SEQ_RDATA: fits = (cmd == CMD_RD_WORD);
          SEQ_WDATA: fits = (cmd == CMD_WR_WORD);
          default:   fits = (cmd == CMD_STATUS);
        endcase
      end while (fits);
      queue_request(cmd, 28'($urandom), 8'($urandom), 16'($urandom));
    end
  endtask

  function automatic logic [27:0] pick_lba();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return LBA_MAX;
      default: return 28'($urandom);
    endcase
  endfunction

  // Answer a wait: zero to two busy polls, then one with BSY clear.
  task automatic queue_wait();
    logic [7:0] st;
    repeat ($urandom_range(0, 2)) begin
      maybe_noise(SEQ_POLL);
      st = 8'($urandom);
      st[BSY_BIT] = 1'b1;
      queue_request(CMD_STATUS, 28'($urandom), st, 16'($urandom));
    end
    maybe_noise(SEQ_POLL);
    st = 8'($urandom);
    st[BSY_BIT] = 1'b0;
    queue_request(CMD_STATUS, 28'($urandom), st, 16'($urandom));
  endtask

  // Read with errs failed checks; give_up adds one more and expects the
  // sequencer to quit, which needs errs equal to the retry limit. Otherwise
  // send words data words; a full sector also answers the closing wait.
  task automatic queue_read(int errs, bit give_up, int words);
    logic [7:0] st;
    maybe_noise(SEQ_IDLE);
    queue_request(CMD_START_RD, pick_lba(), 8'($urandom), 16'($urandom));
    for (int i = 0; i <= errs; i++) begin
      queue_wait();
      queue_wait();
      maybe_noise(SEQ_CHECK);
      st = 8'($urandom);
      if (i < errs || give_up) begin
        while (!(st[ERR_BIT] || st[DF_BIT] || !st[DRQ_BIT])) st = 8'($urandom);
      end else begin
        st[ERR_BIT] = 1'b0;
        st[DF_BIT]  = 1'b0;
        st[DRQ_BIT] = 1'b1;
      end
      queue_request(CMD_STATUS, 28'($urandom), st, 16'($urandom));
    end
    if (!give_up) begin
      repeat (words) begin
        maybe_noise(SEQ_RDATA);
        queue_request(CMD_RD_WORD, 28'($urandom), 8'($urandom), 16'($urandom));
      end
      if (words >= SECTOR_WORDS) queue_wait();
    end
  endtask

  task automatic queue_write();
    maybe_noise(SEQ_IDLE);
    queue_request(CMD_START_WR, pick_lba(), 8'($urandom), 16'($urandom));
    repeat (3) queue_wait();
    repeat (SECTOR_WORDS) begin
      maybe_noise(SEQ_WDATA);
      queue_request(CMD_WR_WORD, 28'($urandom), 8'($urandom), 16'($urandom));
    end
    queue_wait();
  endtask

  // Wait for the request queue and the owed results to drain, then give an
  // item that causes nothing time to pass through before touching config.
  task automatic settle();
    do @(negedge clk);
    while (pending_q.size() != 0 || s_tvalid || owed_q.size() != 0);
    repeat (SETTLE_TICKS) @(negedge clk);
  endtask

  // APB setup then access phase; mirror the register once the access completes.
  task automatic write_register(logic [APB_ADDR_W-1:0] addr, logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == REG_ADDR_SLAVE) cfg_slave = value[0];
    else cfg_retry = value[3:0];
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed, reset configuration (master drive, retry limit 4).
    // Idle: status, data words and undefined codes must all be dropped.
    queue_request(CMD_STATUS,  '0, 8'h00, 16'h0000);
    queue_request(CMD_RD_WORD, '0, 8'h00, 16'hFFFF);
    queue_request(CMD_WR_WORD, LBA_MAX, 8'hFF, 16'h0000);
    queue_request(3'd5, LBA_MAX, 8'hFF, 16'hFFFF);
    queue_request(3'd7, '0, 8'h00, 16'h0000);
    // Read at the top address; one busy poll, then a start that must be
    // ignored while the transfer runs.
    queue_request(CMD_START_RD, LBA_MAX, 8'h00, 16'h0000);
    queue_request(CMD_STATUS, '0, 8'hFF, 16'h0000);
    queue_request(CMD_STATUS, '0, 8'h7F, 16'h0000);
    queue_request(CMD_START_WR, '0, 8'h00, 16'h0000);
    queue_request(CMD_STATUS, '0, 8'h00, 16'h0000);
    // Check failures: ERR, DF with DRQ, missing DRQ, ERR with DRQ, then a
    // fifth error at the limit ends the read with a failed done.
    queue_request(CMD_STATUS, '0, 8'h01, 16'h0000);
    queue_request(CMD_STATUS, '0, 8'h00, 16'h0000);
    queue_request(CMD_STATUS, '0, 8'h00, 16'h0000);
    queue_request(CMD_STATUS, '0, 8'h28, 16'h0000);
    queue_request(CMD_STATUS, '0, 8'h00, 16'h0000);
    queue_request(CMD_STATUS, '0, 8'h00, 16'h0000);
    queue_request(CMD_STATUS, '0, 8'h00, 16'h0000);
    queue_request(CMD_STATUS, '0, 8'h00, 16'h0000);
    queue_request(CMD_STATUS, '0, 8'h00, 16'h0000);
    queue_request(CMD_STATUS, '0, 8'h09, 16'h0000);
    queue_request(CMD_STATUS, '0, 8'h00, 16'h0000);
    queue_request(CMD_STATUS, '0, 8'h00, 16'h0000);
    queue_request(CMD_STATUS, '0, 8'hF6, 16'h0000);
    settle();

    // Slave drive, no retries: the first bad check ends a read; one full
    // sector write with flush in between.
    write_register(REG_ADDR_SLAVE, 32'd1);
    write_register(REG_ADDR_RETRY, 32'd0);
    queue_read(int'(cfg_retry), 1'b1, 0);
    queue_write();
    queue_read(int'(cfg_retry), 1'b1, 0);
    settle();

    // Master drive, highest retry limit: exhaust all retries, then a read
    // that recovers from up to three errors and streams part of a sector.
    write_register(REG_ADDR_SLAVE, 32'd0);
    write_register(REG_ADDR_RETRY, 32'd15);
    queue_read(int'(cfg_retry), 1'b1, 0);
    queue_read(int'($urandom_range(0, 3)), 1'b0, PART_WORDS);
    settle();
    repeat (2 * SETTLE_TICKS) @(negedge clk);

    if (fault_count == 0 && owed_q.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/ata_seq_pkg.sv
hw/rtl/ata_seq_regs.sv
hw/rtl/ata_seq_ctrl.sv
hw/rtl/ata_seq_expand.sv
hw/rtl/ata_pio_sector_sequencer.sv
sim/testbench.sv
